>>> sv/sce_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sce_pkg
// Types and codes shared by the scatter elements matrix store.
// ----------------------------------------------------------------------------
package sce_pkg;

  localparam int unsigned CntW    = 7;
  localparam int unsigned PosW    = 6;
  localparam int unsigned IdxW    = 32;
  localparam int unsigned OutW    = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned StatW   = 2;

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_SCATTER = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  localparam logic [StatW-1:0] ST_DONE = 2'd0;
  localparam logic [StatW-1:0] ST_IDX  = 2'd1;
  localparam logic [StatW-1:0] ST_POS  = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_MATRIX_ROWS  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MATRIX_COLS  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_UPDATE_ROWS  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_UPDATE_COLS  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SCATTER_AXIS = 3'd4;

  typedef struct packed {
    logic [1:0]             cmd;
    logic [PosW-1:0]        pos_row;
    logic [PosW-1:0]        pos_col;
    logic signed [IdxW-1:0] target_index;
    logic [31:0]            word_in;
  } in_item_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [OutW-1:0]  word_out;
  } out_item_t;

  // what the back part does with one queued item
  typedef struct packed {
    logic             wr;
    logic             rd;
    logic [StatW-1:0] status;
  } op_t;

  localparam int unsigned OpW = $bits(op_t);

endpackage
`default_nettype wire

>>> sv/sce_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sce_front
// Holds the size registers, bounds-checks each item and turns it into a
// store operation with a flat address.
// ----------------------------------------------------------------------------
module sce_front import sce_pkg::*; #(
  parameter int unsigned MAX_ROWS  = 64,
  parameter int unsigned MAX_COLS  = 64,
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned AddrW     = 12
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [CntW-1:0]      cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire in_item_t             in_item_i,
  output logic                      push_valid_o,
  input  wire logic                 push_ready_i,
  output op_t                       push_op_o,
  output logic [AddrW-1:0]          push_addr_o,
  output logic [WORD_BITS-1:0]      push_word_o
);

  logic [CntW-1:0] mrows_q, mcols_q, urows_q, ucols_q;
  logic            axis_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mrows_q <= CntW'(64);
      mcols_q <= CntW'(64);
      urows_q <= CntW'(64);
      ucols_q <= CntW'(64);
      axis_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MATRIX_ROWS:  mrows_q <= cfg_wdata_i;
        REG_MATRIX_COLS:  mcols_q <= cfg_wdata_i;
        REG_UPDATE_ROWS:  urows_q <= cfg_wdata_i;
        REG_UPDATE_COLS:  ucols_q <= cfg_wdata_i;
        REG_SCATTER_AXIS: axis_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  logic [CntW-1:0] mr, mc, row, col, trow, tcol, idx_lo;
  logic            idx_hi_zero, mat_ok, pos_ok, idx_ok;

  always_comb begin
    mr = ({25'd0, mrows_q} > 32'(MAX_ROWS)) ? CntW'(MAX_ROWS) : mrows_q;
    mc = ({25'd0, mcols_q} > 32'(MAX_COLS)) ? CntW'(MAX_COLS) : mcols_q;
    row = {1'b0, in_item_i.pos_row};
    col = {1'b0, in_item_i.pos_col};
    idx_lo      = in_item_i.target_index[CntW-1:0];
    idx_hi_zero = (in_item_i.target_index[IdxW-1:CntW] == '0);
    mat_ok = (row < mr) && (col < mc);
    pos_ok = (row < urows_q) && (col < ucols_q) && (axis_q ? (row < mr) : (col < mc));
    idx_ok = idx_hi_zero && (idx_lo < (axis_q ? mc : mr));

    push_op_o = '{wr: 1'b0, rd: 1'b0, status: ST_DONE};
    trow = row;
    tcol = col;
    case (in_item_i.cmd)
      CMD_LOAD, CMD_READ: begin
        if (!mat_ok) begin
          push_op_o.status = ST_POS;
        end else if (in_item_i.cmd == CMD_LOAD) begin
          push_op_o.wr = 1'b1;
        end else begin
          push_op_o.rd = 1'b1;
        end
      end
      CMD_SCATTER: begin
        if (axis_q) begin
          tcol = idx_lo;
        end else begin
          trow = idx_lo;
        end
        if (!pos_ok) begin
          push_op_o.status = ST_POS;
        end else if (!idx_ok) begin
          push_op_o.status = ST_IDX;
        end else begin
          push_op_o.wr = 1'b1;
        end
      end
      default: ;
    endcase

    push_addr_o = AddrW'(AddrW'(trow) * AddrW'(MAX_COLS) + AddrW'(tcol));
    push_word_o = WORD_BITS'(in_item_i.word_in);
  end

  assign push_valid_o = in_valid_i;
  assign in_ready_o   = push_ready_i;

endmodule
`default_nettype wire

>>> sv/sce_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sce_queue
// Two-entry queue between the checking front and the store back.
// ----------------------------------------------------------------------------
module sce_queue #(
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [Width-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic [Width-1:0]      pop_data_o
);

  logic [Width-1:0] slot_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_data_o = slot_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (pop) begin
        rptr_q <= ~rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

>>> sv/sce_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sce_back
// Matrix memory and result register: carries out one queued write or read
// per cycle while the result slot is free or being taken.
// ----------------------------------------------------------------------------
module sce_back import sce_pkg::*; #(
  parameter int unsigned Depth     = 4096,
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned AddrW     = 12
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 pop_valid_i,
  output logic                      pop_ready_o,
  input  wire op_t                  pop_op_i,
  input  wire logic [AddrW-1:0]     pop_addr_i,
  input  wire logic [WORD_BITS-1:0] pop_word_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output out_item_t                 out_item_o
);

  logic [WORD_BITS-1:0] mem [Depth];
  logic [WORD_BITS-1:0] rdata_q;
  logic                 valid_q, rd_q;
  logic [StatW-1:0]     status_q;
  logic                 take;

  assign pop_ready_o = !valid_q || out_ready_i;
  assign take        = pop_valid_i && pop_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_ready_o) begin
      valid_q <= pop_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      rd_q     <= pop_op_i.rd;
      status_q <= pop_op_i.status;
      if (pop_op_i.wr) begin
        mem[pop_addr_i] <= pop_word_i;
      end
      if (pop_op_i.rd) begin
        rdata_q <= mem[pop_addr_i];
      end
    end
  end

  assign out_valid_o         = valid_q;
  assign out_item_o.status   = status_q;
  assign out_item_o.word_out = rd_q ? OutW'(rdata_q) : '0;

endmodule
`default_nettype wire

>>> sv/scatter_elements_2d.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scatter_elements_2d
// 2-D word matrix store with load, element scatter and read items.
// ----------------------------------------------------------------------------
//  channel  handshake               payload
//  in       in_valid_i/in_ready_o   in_item_i  (cmd, pos_row, pos_col, ...)
//  out      out_valid_o/out_ready_i out_item_o (status, word_out)
//  cfg      cfg_we_i                cfg_idx_i, cfg_wdata_i
//
//  one item per cycle sustained while out_ready_i is high; a taken item is
//  registered before its result is valid: it first lands in a queue slot,
//  then in the result register that the memory read port fills
//  reset sets the sizes to 64 and the axis to 0 and empties the queue and
//  result slot; the matrix is not cleared, so no start-up pass is needed
//  a stalled output fills the result slot and then the two-entry queue
// ----------------------------------------------------------------------------
module scatter_elements_2d import sce_pkg::*; #(
  parameter int unsigned MAX_ROWS  = 64,
  parameter int unsigned MAX_COLS  = 64,
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CntW-1:0]    cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire in_item_t           in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output out_item_t               out_item_o
);

  localparam int unsigned Depth = MAX_ROWS * MAX_COLS;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned QW    = OpW + AddrW + WORD_BITS;

  logic                 push_valid, push_ready, pop_valid, pop_ready;
  op_t                  push_op, pop_op;
  logic [AddrW-1:0]     push_addr, pop_addr;
  logic [WORD_BITS-1:0] push_word, pop_word;
  logic [QW-1:0]        pop_data;

  sce_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .WORD_BITS(WORD_BITS),
    .AddrW    (AddrW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_op_o   (push_op),
    .push_addr_o (push_addr),
    .push_word_o (push_word)
  );

  sce_queue #(
    .Width(QW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i ({push_op, push_addr, push_word}),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  assign {pop_op, pop_addr, pop_word} = pop_data;

  sce_back #(
    .Depth    (Depth),
    .WORD_BITS(WORD_BITS),
    .AddrW    (AddrW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_op_i   (pop_op),
    .pop_addr_i (pop_addr),
    .pop_word_i (pop_word),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule
`default_nettype wire
